// File: sv/tdtt_pkg.sv
// Package for the task delay timer table: payload structs, op and event codes,
// controller states and the command/status groups. No dependencies.
package tdtt_pkg;

   localparam int NUM_TASKS   = 32;
   localparam int MAX_RESULTS = 32;
   localparam int TASK_W      = $clog2(NUM_TASKS);
   localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
   localparam int ID_W        = 5;
   localparam int DLY_W       = 32;

   localparam logic [2:0] OP_TICK         = 3'd0;
   localparam logic [2:0] OP_TIMED_WAIT   = 3'd1;
   localparam logic [2:0] OP_TIMED_LEAVE  = 3'd2;
   localparam logic [2:0] OP_READY_WAIT   = 3'd3;
   localparam logic [2:0] OP_READY_LEAVE  = 3'd4;
   localparam logic [2:0] OP_READY_RESUME = 3'd5;

   localparam logic [2:0] EV_ACCEPT  = 3'd0;
   localparam logic [2:0] EV_REJECT  = 3'd1;
   localparam logic [2:0] EV_TIMEOUT = 3'd2;
   localparam logic [2:0] EV_READY   = 3'd3;
   localparam logic [2:0] EV_NONE    = 3'd4;

   typedef struct packed {
      logic [2:0]       op;
      logic [ID_W-1:0]  task_req;
      logic [DLY_W-1:0] delay;
   } req_type;

   typedef struct packed {
      logic [ID_W-1:0] task_id;
      logic [2:0]      event_res;
      logic            timed_out;
      logic            last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_FLUSH,
      ST_SINGLE
   } state_type;

   typedef struct packed {
      logic load;
      logic scan_issue;
      logic single;
      logic flush;
   } cmd_type;

   typedef struct packed {
      logic ptr_last;
      logic adv;
      logic ev_busy;
      logic out_free;
   } stat_type;

endpackage

// File: sv/task_delay_timer_table.sv
// Wait/leave ops: accepted in idle and latched; in the single state the result is
// loaded into the output register once it is free; next transfer taken after that.
// Tick/resume: one slot per cycle through the delay memory read port unless an
// output stall holds the scan; results are held back, the final one sent at flush.
// Reset clears list bits, timeout flags and control; the delay memory is not cleared.
module task_delay_timer_table (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  tdtt_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output tdtt_pkg::rsp_type rsp_payload
);

   tdtt_pkg::cmd_type  cmd;
   tdtt_pkg::stat_type stat;

   tdtt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (req_payload.op),
      .stat      (stat),
      .req_stall (req_stall),
      .cmd       (cmd)
   );

   tdtt_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cmd         (cmd),
      .rsp_stall   (rsp_stall),
      .stat        (stat),
      .rsp_valid   (rsp_valid),
      .rsp_payload (rsp_payload)
   );

endmodule

// File: sv/tdtt_ctrl.sv
// Controller for the task delay timer table: sequences single ops and slot scans.
// Depends on tdtt_pkg.
module tdtt_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  logic [2:0]        req_op,
   input  tdtt_pkg::stat_type stat,
   output logic              req_stall,
   output tdtt_pkg::cmd_type cmd
);

   tdtt_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tdtt_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         tdtt_pkg::ST_IDLE: begin
            if (req_valid) begin
               priority if (req_op == tdtt_pkg::OP_TICK || req_op == tdtt_pkg::OP_READY_RESUME)
                  state_in = tdtt_pkg::ST_SCAN;
               else if (req_op == tdtt_pkg::OP_TIMED_WAIT || req_op == tdtt_pkg::OP_TIMED_LEAVE
                        || req_op == tdtt_pkg::OP_READY_WAIT
                        || req_op == tdtt_pkg::OP_READY_LEAVE)
                  state_in = tdtt_pkg::ST_SINGLE;
               else
                  state_in = tdtt_pkg::ST_FLUSH;
            end
         end
         tdtt_pkg::ST_SCAN: begin
            if (stat.adv && stat.ptr_last) state_in = tdtt_pkg::ST_DRAIN;
         end
         tdtt_pkg::ST_DRAIN: begin
            if (!stat.ev_busy) state_in = tdtt_pkg::ST_FLUSH;
         end
         tdtt_pkg::ST_FLUSH: begin
            if (stat.out_free) state_in = tdtt_pkg::ST_IDLE;
         end
         tdtt_pkg::ST_SINGLE: begin
            if (stat.out_free) state_in = tdtt_pkg::ST_IDLE;
         end
         default: state_in = tdtt_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd        = '0;
      req_stall  = 1'b1;
      unique case (state_ff)
         tdtt_pkg::ST_IDLE: begin
            req_stall = 1'b0;
            cmd.load  = req_valid;
         end
         tdtt_pkg::ST_SCAN:   cmd.scan_issue = 1'b1;
         tdtt_pkg::ST_DRAIN:  cmd.scan_issue = 1'b0;
         tdtt_pkg::ST_FLUSH:  cmd.flush      = 1'b1;
         tdtt_pkg::ST_SINGLE: cmd.single     = 1'b1;
         default:             cmd            = '0;
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdtt_pkg::ST_SCAN && stat.adv && stat.ptr_last)
      |=> state_ff == tdtt_pkg::ST_DRAIN)
      else $error("scan did not end after last slot");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == tdtt_pkg::ST_FLUSH) |-> !stat.ev_busy)
      else $error("flush while a slot is still in evaluation");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff != tdtt_pkg::ST_IDLE && $past(state_ff) == tdtt_pkg::ST_IDLE)
      |-> $past(req_valid))
      else $error("left idle without a transfer");

endmodule

// File: sv/tdtt_datapath.sv
// Datapath for the task delay timer table: list bits, timeout flags, delay memory,
// scan pipeline, held-back result and output register. Depends on tdtt_pkg.
module tdtt_datapath (
   input  logic               clock,
   input  logic               reset,
   input  tdtt_pkg::req_type  req_payload,
   input  tdtt_pkg::cmd_type  cmd,
   input  logic               rsp_stall,
   output tdtt_pkg::stat_type stat,
   output logic               rsp_valid,
   output tdtt_pkg::rsp_type  rsp_payload
);

   logic [tdtt_pkg::NUM_TASKS-1:0] timed_ff, timed_in;
   logic [tdtt_pkg::NUM_TASKS-1:0] ready_ff, ready_in;
   logic [tdtt_pkg::NUM_TASKS-1:0] flag_ff, flag_in;

   logic [tdtt_pkg::DLY_W-1:0] delay_mem [tdtt_pkg::NUM_TASKS];
   logic [tdtt_pkg::DLY_W-1:0] rd_data_ff;

   logic [2:0]                  op_ff;
   logic [tdtt_pkg::ID_W-1:0]   task_ff;
   logic [tdtt_pkg::DLY_W-1:0]  delay_ff;

   logic [tdtt_pkg::TASK_W-1:0] ptr_ff, ptr_in;
   logic                        ev_valid_ff, ev_valid_in;
   logic [tdtt_pkg::TASK_W-1:0] ev_idx_ff, ev_idx_in;

   logic                        pend_valid_ff, pend_valid_in;
   tdtt_pkg::rsp_type           pend_ff, pend_in;
   logic [tdtt_pkg::CNT_W-1:0]  found_ff, found_in;

   logic                        rsp_valid_ff, rsp_valid_in;
   tdtt_pkg::rsp_type           rsp_ff, rsp_in;

   logic                        mem_we;
   logic [tdtt_pkg::TASK_W-1:0] mem_waddr;
   logic [tdtt_pkg::DLY_W-1:0]  mem_wdata;
   logic                        rd_en;

   logic                        out_free, adv, blocked, do_eval;
   logic                        ev_t, ev_r, ev_f, tw, rw, wake, emit_ok;
   logic [tdtt_pkg::DLY_W-1:0]  dec;
   tdtt_pkg::rsp_type           ev_res;

   logic [tdtt_pkg::TASK_W-1:0] sidx;
   logic                        slot_ok, s_t, s_r, s_f;

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      ev_t = timed_ff[ev_idx_ff];
      ev_r = ready_ff[ev_idx_ff];
      ev_f = flag_ff[ev_idx_ff];
      dec  = tdtt_pkg::DLY_W'(ev_t) + tdtt_pkg::DLY_W'(ev_r);
      if (op_ff == tdtt_pkg::OP_TICK) begin
         tw = ev_t && (rd_data_ff == '0);
         rw = ev_r && (ev_t ? (rd_data_ff == tdtt_pkg::DLY_W'(1)) : (rd_data_ff == '0));
      end else begin
         tw = 1'b0;
         rw = ev_r;
      end
      wake    = tw || rw;
      emit_ok = wake && (found_ff < tdtt_pkg::CNT_W'(tdtt_pkg::MAX_RESULTS));
      ev_res.task_id   = tdtt_pkg::ID_W'(ev_idx_ff);
      ev_res.event_res = tw ? tdtt_pkg::EV_TIMEOUT : tdtt_pkg::EV_READY;
      ev_res.timed_out = ev_f || tw;
      ev_res.last      = 1'b0;
      blocked = ev_valid_ff && emit_ok && pend_valid_ff && !out_free;
      adv     = !blocked;
      do_eval = ev_valid_ff && adv;
      rd_en   = cmd.scan_issue && adv;
   end

   assign sidx    = tdtt_pkg::TASK_W'(task_ff);
   assign slot_ok = int'(task_ff) < tdtt_pkg::NUM_TASKS;
   assign s_t     = timed_ff[sidx];
   assign s_r     = ready_ff[sidx];
   assign s_f     = flag_ff[sidx];

   always_comb begin
      timed_in      = timed_ff;
      ready_in      = ready_ff;
      flag_in       = flag_ff;
      ptr_in        = ptr_ff;
      ev_valid_in   = ev_valid_ff;
      ev_idx_in     = ev_idx_ff;
      pend_valid_in = pend_valid_ff;
      pend_in       = pend_ff;
      found_in      = found_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = ev_idx_ff;
      mem_wdata     = rd_data_ff - dec;

      if (cmd.load) begin
         ptr_in        = '0;
         ev_valid_in   = 1'b0;
         pend_valid_in = 1'b0;
         found_in      = '0;
      end

      if (adv) begin
         ev_valid_in = cmd.scan_issue;
      end
      if (rd_en) begin
         ev_idx_in = ptr_ff;
         ptr_in    = ptr_ff + tdtt_pkg::TASK_W'(1);
      end

      if (do_eval) begin
         timed_in[ev_idx_ff] = ev_t && !tw;
         ready_in[ev_idx_ff] = ev_r && !rw;
         flag_in[ev_idx_ff]  = ev_f || tw;
         mem_we = (op_ff == tdtt_pkg::OP_TICK) && (ev_t || ev_r);
         if (emit_ok) begin
            if (pend_valid_ff) begin
               rsp_valid_in = 1'b1;
               rsp_in       = pend_ff;
            end
            pend_valid_in = 1'b1;
            pend_in       = ev_res;
            found_in      = found_ff + tdtt_pkg::CNT_W'(1);
         end
      end

      if (cmd.flush && out_free) begin
         rsp_valid_in = 1'b1;
         if (pend_valid_ff) begin
            rsp_in      = pend_ff;
            rsp_in.last = 1'b1;
         end else begin
            rsp_in.task_id   = '0;
            rsp_in.event_res = tdtt_pkg::EV_NONE;
            rsp_in.timed_out = 1'b0;
            rsp_in.last      = 1'b1;
         end
         pend_valid_in = 1'b0;
      end

      if (cmd.single && out_free) begin
         rsp_valid_in     = 1'b1;
         rsp_in.task_id   = task_ff;
         rsp_in.last      = 1'b1;
         rsp_in.event_res = tdtt_pkg::EV_REJECT;
         rsp_in.timed_out = slot_ok && s_f;
         mem_waddr        = sidx;
         mem_wdata        = delay_ff;
         unique case (op_ff)
            tdtt_pkg::OP_TIMED_WAIT: begin
               if (slot_ok && !s_t) begin
                  timed_in[sidx]   = 1'b1;
                  mem_we           = 1'b1;
                  rsp_in.event_res = tdtt_pkg::EV_ACCEPT;
               end
            end
            tdtt_pkg::OP_TIMED_LEAVE: begin
               if (slot_ok && s_t) begin
                  timed_in[sidx]   = 1'b0;
                  flag_in[sidx]    = 1'b0;
                  rsp_in.event_res = tdtt_pkg::EV_ACCEPT;
                  rsp_in.timed_out = 1'b0;
               end
            end
            tdtt_pkg::OP_READY_WAIT: begin
               if (slot_ok && !s_r) begin
                  ready_in[sidx]   = 1'b1;
                  mem_we           = 1'b1;
                  rsp_in.event_res = tdtt_pkg::EV_ACCEPT;
               end
            end
            tdtt_pkg::OP_READY_LEAVE: begin
               if (slot_ok && s_r) begin
                  ready_in[sidx]   = 1'b0;
                  rsp_in.event_res = tdtt_pkg::EV_ACCEPT;
               end
            end
            default: rsp_in.event_res = tdtt_pkg::EV_REJECT;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) delay_mem[mem_waddr] <= mem_wdata;
      if (rd_en) rd_data_ff <= delay_mem[ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff    <= req_payload.op;
         task_ff  <= req_payload.task_req;
         delay_ff <= req_payload.delay;
      end
      ev_idx_ff <= ev_idx_in;
      pend_ff   <= pend_in;
      rsp_ff    <= rsp_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timed_ff      <= '0;
         ready_ff      <= '0;
         flag_ff       <= '0;
         ptr_ff        <= '0;
         ev_valid_ff   <= 1'b0;
         pend_valid_ff <= 1'b0;
         found_ff      <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         timed_ff      <= timed_in;
         ready_ff      <= ready_in;
         flag_ff       <= flag_in;
         ptr_ff        <= ptr_in;
         ev_valid_ff   <= ev_valid_in;
         pend_valid_ff <= pend_valid_in;
         found_ff      <= found_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   assign stat.ptr_last = ptr_ff == tdtt_pkg::TASK_W'(tdtt_pkg::NUM_TASKS - 1);
   assign stat.adv      = adv;
   assign stat.ev_busy  = ev_valid_ff;
   assign stat.out_free = out_free;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

   assert property (@(posedge clock) disable iff (reset)
      !(ev_valid_ff && (cmd.flush || cmd.single)))
      else $error("scan evaluation overlaps a result load");

   assert property (@(posedge clock) disable iff (reset)
      found_ff <= tdtt_pkg::CNT_W'(tdtt_pkg::MAX_RESULTS))
      else $error("result count past limit");

   assert property (@(posedge clock) disable iff (reset)
      pend_valid_ff |-> found_ff != '0)
      else $error("held result without count");

   assert property (@(posedge clock) disable iff (reset)
      ((cmd.single || cmd.flush) && out_free) |=> (rsp_valid_ff && rsp_ff.last))
      else $error("final result not marked last");

endmodule
